/* rtl/core/mesh_bbox_normalizer_unit_assert.svh */
// Assertion helpers used by the controller.
`ifndef MESH_BBOX_NORMALIZER_UNIT_ASSERT_SVH
`define MESH_BBOX_NORMALIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MBN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbn check failed");

// Next-cycle implication, checked out of reset.
`define MBN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbn check failed");

`endif

/* rtl/core/mbn_pkg.sv */
`default_nettype none
package mbn_pkg;

    localparam int COORD_W = 32;
    localparam int VIDX_W  = 10;
    localparam int RAD_W   = 31;
    localparam int CNT_W   = 5;

    localparam logic [CNT_W-1:0] STEP_LAST = 5'd31;
    localparam logic [CNT_W-1:0] SQ_LAST   = 5'd3;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_FETCH = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_DEGEN = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_SQ,
        S_ROOT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       start;
        logic       div_init;
        logic       div_step;
        logic       sq_clear;
        logic [1:0] sq_sel;
        logic       sq_step;
        logic       root_init;
        logic       root_step;
        logic       emit;
        logic [1:0] emit_status;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic degen;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/core/mbn_ctrl.sv */
`default_nettype none
`include "mesh_bbox_normalizer_unit_assert.svh"
module mbn_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire  [1:0]        i_mode,
    output logic              o_in_ready,
    input  mbn_pkg::t_stat    i_stat,
    output mbn_pkg::t_cmd     o_cmd
);
    import mbn_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_status, n_status;
    logic             w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_status <= STATUS_OK;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_status <= n_status;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_acc && i_mode == MODE_FETCH) begin
                    if (i_stat.empty) begin
                        n_status = STATUS_EMPTY;
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (i_stat.degen) begin
                    n_status = STATUS_DEGEN;
                    n_state  = S_FINISH;
                end else begin
                    n_status = STATUS_OK;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == STEP_LAST) begin
                    n_cnt   = '0;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == STEP_LAST) begin
                    n_cnt   = '0;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.emit_status = r_status;
        o_cmd.sq_sel      = r_cnt[1:0];
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load  = w_acc && (i_mode == MODE_LOAD);
                o_cmd.clear = w_acc && (i_mode == MODE_CLEAR);
                o_cmd.start = w_acc && (i_mode == MODE_FETCH) && !i_stat.empty;
            end
            S_READ:   o_cmd.div_init = !i_stat.degen;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_SQ: begin
                o_cmd.sq_step   = 1'b1;
                o_cmd.sq_clear  = (r_cnt == '0);
                o_cmd.root_init = (r_cnt == SQ_LAST);
            end
            S_ROOT:   o_cmd.root_step = 1'b1;
            S_FINISH: o_cmd.emit = i_stat.out_free;
            default: ;
        endcase
    end

    `MBN_ASSERT_NXT(a_fetch_leaves_idle, i_clk, i_rst_n,
        w_acc && i_mode == MODE_FETCH, r_state != S_IDLE)
    `MBN_ASSERT_NXT(a_hold_finish, i_clk, i_rst_n,
        r_state == S_FINISH && !i_stat.out_free, r_state == S_FINISH)
    `MBN_ASSERT_IMP(a_sq_window, i_clk, i_rst_n,
        r_state == S_SQ, r_cnt <= SQ_LAST)

endmodule
`default_nettype wire

/* rtl/core/mbn_datapath.sv */
`default_nettype none
module mbn_datapath #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  mbn_pkg::t_cmd        i_cmd,
    output mbn_pkg::t_stat       o_stat,
    input  wire  [31:0]          i_x,
    input  wire  [31:0]          i_y,
    input  wire  [31:0]          i_z,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [31:0]          o_nx,
    output logic [31:0]          o_ny,
    output logic [31:0]          o_nz,
    output logic [9:0]           o_vidx,
    output logic                 o_last,
    output logic [30:0]          o_rad,
    output logic [31:0]          o_cx,
    output logic [31:0]          o_cy,
    output logic [31:0]          o_cz,
    output logic [1:0]           o_status
);
    import mbn_pkg::*;

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_VERTICES);

    logic [95:0] r_mem [MAX_VERTICES];
    logic [95:0] r_rd;

    logic signed [31:0] r_min [3];
    logic signed [31:0] r_max [3];
    logic [CW-1:0] r_count, r_rp, r_idx;
    logic          r_last;
    logic [31:0]   r_scale;
    logic [30:0]   r_rad;
    logic [31:0]   r_c [3];

    logic [31:0] r_rem [3];
    logic [31:0] r_q   [3];
    logic        r_neg [3];

    logic [63:0] r_prod, r_acc, r_sn;
    logic [34:0] r_srem;
    logic [31:0] r_root;

    logic        r_valid;
    logic [31:0] r_onx, r_ony, r_onz, r_ocx, r_ocy, r_ocz;
    logic [9:0]  r_ovidx;
    logic        r_olast;
    logic [30:0] r_orad;
    logic [1:0]  r_ostat;

    logic [31:0] w_in [3];
    logic [31:0] w_c [3];
    logic [31:0] w_ext [3];
    logic [31:0] w_e;
    logic [31:0] w_qsel;
    logic [30:0] w_rclamp, w_radnew;
    logic [34:0] w_st, w_trial;

    assign w_in[0] = i_x;
    assign w_in[1] = i_y;
    assign w_in[2] = i_z;

    always_comb begin
        logic signed [32:0] s;
        for (int a = 0; a < 3; a++) begin
            s = 33'(r_min[a]) + 33'(r_max[a]);
            w_c[a]   = 32'(s >>> 1);
            w_ext[a] = 32'(33'(r_max[a]) - 33'(r_min[a]));
        end
        w_e = w_ext[0];
        if (w_ext[1] > w_e) w_e = w_ext[1];
        if (w_ext[2] > w_e) w_e = w_ext[2];
    end

    assign o_stat.empty    = (r_rp >= r_count);
    assign o_stat.degen    = (r_scale == '0);
    assign o_stat.out_free = !r_valid || i_ready;

    // store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count != FULL) r_mem[r_count[IW-1:0]] <= {i_z, i_y, i_x};
        if (i_cmd.start) r_rd <= r_mem[r_rp[IW-1:0]];
    end

    // box, pointer, scale, radius
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rp    <= '0;
            r_scale <= '0;
            r_rad   <= '0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= '0;
                r_max[a] <= '0;
            end
        end else if (i_cmd.clear) begin
            r_count <= '0;
            r_rp    <= '0;
            r_scale <= '0;
            r_rad   <= '0;
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= '0;
                r_max[a] <= '0;
            end
        end else if (i_cmd.load && r_count != FULL) begin
            for (int a = 0; a < 3; a++) begin
                if (r_count == '0 || $signed(w_in[a]) < r_min[a]) r_min[a] <= w_in[a];
                if (r_count == '0 || $signed(w_in[a]) > r_max[a]) r_max[a] <= w_in[a];
            end
            r_count <= r_count + CW'(1);
            r_rp    <= '0;
            r_rad   <= '0;
        end else if (i_cmd.start) begin
            r_scale <= w_e;
            r_rp    <= r_rp + CW'(1);
        end else if (i_cmd.emit && i_cmd.emit_status == STATUS_OK) begin
            r_rad <= w_radnew;
        end
    end

    // fetch context
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx  <= r_rp;
            r_last <= (r_rp + CW'(1) == r_count);
            for (int a = 0; a < 3; a++) r_c[a] <= w_c[a];
        end
    end

    // three restoring dividers, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        logic signed [32:0] d;
        logic [32:0]        mag;
        logic [63:0]        num;
        logic [32:0]        t;
        for (int a = 0; a < 3; a++) begin
            if (i_cmd.div_init) begin
                d   = $signed(33'($signed(r_rd[32*a +: 32]))) - $signed(33'($signed(r_c[a])));
                mag = d[32] ? 33'(-d) : 33'(d);
                num = (64'(mag) << 30) + 64'(r_scale >> 1);
                r_neg[a] <= d[32];
                r_rem[a] <= num[63:32];
                r_q[a]   <= num[31:0];
            end else if (i_cmd.div_step) begin
                t = {r_rem[a], r_q[a][31]};
                if (t >= {1'b0, r_scale}) begin
                    r_rem[a] <= 32'(t - {1'b0, r_scale});
                    r_q[a]   <= {r_q[a][30:0], 1'b1};
                end else begin
                    r_rem[a] <= t[31:0];
                    r_q[a]   <= {r_q[a][30:0], 1'b0};
                end
            end
        end
    end

    // sum of squares through one multiplier
    always_comb begin
        case (i_cmd.sq_sel)
            2'd0:    w_qsel = r_q[0];
            2'd1:    w_qsel = r_q[1];
            default: w_qsel = r_q[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_step) begin
            r_prod <= 64'(w_qsel) * 64'(w_qsel);
            r_acc  <= i_cmd.sq_clear ? '0 : r_acc + r_prod;
        end
    end

    // digit-by-digit square root, one root bit per cycle
    assign w_st    = {r_srem[32:0], r_sn[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_sn   <= r_acc + r_prod;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_sn <= {r_sn[61:0], 2'b00};
            if (w_st >= w_trial) begin
                r_srem <= w_st - w_trial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_srem <= w_st;
                r_root <= {r_root[30:0], 1'b0};
            end
        end
    end

    assign w_rclamp = r_root[31] ? '1 : r_root[30:0];
    assign w_radnew = (w_rclamp > r_rad) ? w_rclamp : r_rad;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ostat <= i_cmd.emit_status;
            case (i_cmd.emit_status)
                STATUS_OK: begin
                    r_onx  <= r_neg[0] ? 32'(-r_q[0]) : r_q[0];
                    r_ony  <= r_neg[1] ? 32'(-r_q[1]) : r_q[1];
                    r_onz  <= r_neg[2] ? 32'(-r_q[2]) : r_q[2];
                    r_orad <= w_radnew;
                end
                default: begin
                    r_onx  <= '0;
                    r_ony  <= '0;
                    r_onz  <= '0;
                    r_orad <= '0;
                end
            endcase
            if (i_cmd.emit_status == STATUS_EMPTY) begin
                r_ovidx <= '0;
                r_olast <= 1'b0;
                r_ocx   <= '0;
                r_ocy   <= '0;
                r_ocz   <= '0;
            end else begin
                r_ovidx <= VIDX_W'(r_idx);
                r_olast <= r_last;
                r_ocx   <= r_c[0];
                r_ocy   <= r_c[1];
                r_ocz   <= r_c[2];
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_nx     = r_onx;
    assign o_ny     = r_ony;
    assign o_nz     = r_onz;
    assign o_vidx   = r_ovidx;
    assign o_last   = r_olast;
    assign o_rad    = r_orad;
    assign o_cx     = r_ocx;
    assign o_cy     = r_ocy;
    assign o_cz     = r_ocz;
    assign o_status = r_ostat;

endmodule
`default_nettype wire

/* rtl/core/mesh_bbox_normalizer_unit.sv */
// Bounding-box normalizer: loads a vertex set, then streams it back scaled
// into the unit cube around the box midpoint.
// Input channel (s_*): tuser carries the mode, tdata the Q16.16 vertex.
//   Mode 0 loads a vertex and widens the box (dropped once the store is full),
//   mode 1 fetches the next vertex, mode 2 clears the set, mode 3 is ignored.
// Output channel (m_*): one beat per fetch; tuser is the status (ok, nothing
//   left, zero extent), tlast flags the final stored vertex, tdata carries
//   the Q2.30 normalized vertex, index, running radius and Q16.16 center.
// Sequencing: load, clear and ignored modes are handled while idle. A fetch
//   runs a store read, a setup step, the divider steps (one quotient bit a
//   cycle, all three axes in parallel), squaring on one multiplier, the
//   square-root steps and a write into the output register. An empty or zero
//   extent fetch skips the divider, squaring and root steps.
// One fetch is in flight at a time; tready is high only while idle.
// Reset (synchronous, active low) empties the set and clears the box, the
//   fetch pointer and the radius; the store contents are not cleared.
// A stalled result holds in the output register; a finished fetch waits for
//   that register to drain, and every input beat, load and clear included,
//   is held off until it does.
`default_nettype none
module mesh_bbox_normalizer_unit #(
    parameter int MAX_VERTICES = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [95:0]  s_tdata,   // coord_x, coord_y, coord_z
    input  wire  [1:0]   s_tuser,   // mode
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [239:0] m_tdata,   // norm_x, norm_y, norm_z, vertex_index,
                                    // radius_so_far, center_x, center_y, center_z, pad
    output logic         m_tlast,   // is_last
    output logic [1:0]   m_tuser    // status
);
    import mbn_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    logic [31:0] w_nx, w_ny, w_nz, w_cx, w_cy, w_cz;
    logic [9:0]  w_vidx;
    logic [30:0] w_rad;

    // sequence the fetch steps
    mbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_mode     (s_tuser),
        .o_in_ready (s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // store, box, dividers, root and result register
    mbn_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_x      (s_tdata[31:0]),
        .i_y      (s_tdata[63:32]),
        .i_z      (s_tdata[95:64]),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_nx     (w_nx),
        .o_ny     (w_ny),
        .o_nz     (w_nz),
        .o_vidx   (w_vidx),
        .o_last   (m_tlast),
        .o_rad    (w_rad),
        .o_cx     (w_cx),
        .o_cy     (w_cy),
        .o_cz     (w_cz),
        .o_status (m_tuser)
    );

    // pack the result beat, lowest field first
    assign m_tdata = {7'd0, w_cz, w_cy, w_cx, w_rad, w_vidx, w_nz, w_ny, w_nx};

endmodule
`default_nettype wire
